FILE: rtl/quadratic_bspline_tessellator_defines.svh
// Assertion macros used by the tessellator sequencer.
`ifndef QUADRATIC_BSPLINE_TESSELLATOR_DEFINES_SVH
`define QUADRATIC_BSPLINE_TESSELLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tessellator assertion failed");
`define QBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tessellator assertion failed");
`else
`define QBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define QBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/qbt_pkg.sv
// Constants, weight tables and types of the quadratic B-spline tessellator.
`default_nettype none

package qbt_pkg;

  localparam int COORD_W  = 32;
  localparam int SAMPLES  = 20;
  localparam int WFRAC    = 16;
  localparam int WW       = WFRAC + 1;
  localparam int PW       = COORD_W + WW + 1;
  localparam int AW       = PW + 2;
  localparam int IDXW     = $clog2(SAMPLES + 1);

  localparam logic [IDXW-1:0] PASS_IDX    = IDXW'(SAMPLES);
  localparam logic [IDXW-1:0] LAST_SAMPLE = IDXW'(SAMPLES - 1);

  localparam longint S2    = longint'(SAMPLES) * longint'(SAMPLES);
  localparam longint S2X2  = 2 * S2;
  localparam longint ONE_L = longint'(1) << WFRAC;

  typedef logic [SAMPLES:0][WW-1:0] wtab_t;

  function automatic longint outer_w(input longint num);
    return (num * ONE_L + S2) / S2X2;
  endfunction

  function automatic wtab_t build_w0();
    wtab_t tab;
    for (int k = 0; k <= SAMPLES; k++) begin
      if (k == SAMPLES) begin
        tab[k] = '0;
      end else begin
        tab[k] = WW'(outer_w(longint'(SAMPLES - k) * longint'(SAMPLES - k)));
      end
    end
    return tab;
  endfunction

  function automatic wtab_t build_w2();
    wtab_t tab;
    for (int k = 0; k <= SAMPLES; k++) begin
      if (k == SAMPLES) begin
        tab[k] = WW'(ONE_L);
      end else begin
        tab[k] = WW'(outer_w(longint'(k) * longint'(k)));
      end
    end
    return tab;
  endfunction

  function automatic wtab_t build_w1();
    wtab_t tab;
    for (int k = 0; k <= SAMPLES; k++) begin
      if (k == SAMPLES) begin
        tab[k] = '0;
      end else begin
        tab[k] = WW'(ONE_L - outer_w(longint'(SAMPLES - k) * longint'(SAMPLES - k))
                 - outer_w(longint'(k) * longint'(k)));
      end
    end
    return tab;
  endfunction

  localparam wtab_t W0_TAB = build_w0();
  localparam wtab_t W1_TAB = build_w1();
  localparam wtab_t W2_TAB = build_w2();

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [IDXW-1:0]           idx;
    logic                      run_end;
    logic                      curve_end;
  } issue_t;

endpackage

`default_nettype wire

FILE: rtl/qbt_point_if.sv
// Control point request channel.
`default_nettype none

interface qbt_point_if;
  import qbt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input final_point,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/qbt_curve_if.sv
// Curve point request channel.
`default_nettype none

interface qbt_curve_if;
  import qbt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic                      run_end;
  logic                      curve_end;

  modport source (output valid, output curve_x, output curve_y, output run_end,
                  output curve_end, input ready);
  modport sink (input valid, input curve_x, input curve_y, input run_end,
                input curve_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/quadratic_bspline_tessellator.sv
// Top level of the uniform quadratic B-spline tessellator.
// From the third control point of a curve on, each point yields twenty curve points, one
// per cycle while the output does not stall (plus a closing point when it ends the curve);
// the first point yields one pass-through point and a non-final second point is absorbed
// at once. The issue sequencer steps one sample index per cycle through the weight tables
// while not stalled, and accepts the next point in the cycle its last sample issues. A
// result is registered in the product registers and then in the result register, and the
// sequencer stalls only when the result register holds an untaken request.
`default_nettype none

module quadratic_bspline_tessellator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qbt_point_if.sink in_i,
  qbt_curve_if.source out_o
);
  import qbt_pkg::*;

  issue_t issue;
  logic   adv;

  qbt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .issue_o (issue)
  );

  qbt_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .adv_o   (adv),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/qbt_seq.sv
// Control point window, curve state and per-sample issue sequencer.
`default_nettype none

`include "quadratic_bspline_tessellator_defines.svh"

module qbt_seq (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  qbt_point_if.sink         in_i,
  input  wire logic         adv_i,
  output qbt_pkg::issue_t   issue_o
);
  import qbt_pkg::*;

  localparam logic [1:0] PTS_NONE = 2'd0;
  localparam logic [1:0] PTS_ONE  = 2'd1;
  localparam logic [1:0] PTS_TWO  = 2'd2;

  logic signed [COORD_W-1:0] older_x_q, older_x_d, older_y_q, older_y_d;
  logic signed [COORD_W-1:0] newer_x_q, newer_x_d, newer_y_q, newer_y_d;
  logic [1:0]                pts_q, pts_d;

  logic                      busy_q, busy_d;
  logic [IDXW-1:0]           cnt_q, cnt_d;
  logic                      fin_q, fin_d;
  logic signed [COORD_W-1:0] wo_x_q, wo_x_d, wo_y_q, wo_y_d;
  logic signed [COORD_W-1:0] wn_x_q, wn_x_d, wn_y_q, wn_y_d;
  logic signed [COORD_W-1:0] wp_x_q, wp_x_d, wp_y_q, wp_y_d;

  logic fire, last, accept, needs_issue;

  assign fire        = busy_q && adv_i;
  assign last        = (cnt_q == PASS_IDX) || ((cnt_q == LAST_SAMPLE) && !fin_q);
  assign in_i.ready  = !busy_q || (adv_i && last);
  assign accept      = in_i.valid && in_i.ready;
  assign needs_issue = (pts_q != PTS_ONE) || in_i.final_point;

  always_comb begin
    older_x_d = older_x_q;
    older_y_d = older_y_q;
    newer_x_d = newer_x_q;
    newer_y_d = newer_y_q;
    pts_d     = pts_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    wo_x_d    = wo_x_q;
    wo_y_d    = wo_y_q;
    wn_x_d    = wn_x_q;
    wn_y_d    = wn_y_q;
    wp_x_d    = wp_x_q;
    wp_y_d    = wp_y_q;

    if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else if (cnt_q == LAST_SAMPLE) begin
        cnt_d = PASS_IDX;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (accept) begin
      busy_d = needs_issue;
      cnt_d  = (pts_q == PTS_TWO) ? '0 : PASS_IDX;
      fin_d  = in_i.final_point;
      wo_x_d = older_x_q;
      wo_y_d = older_y_q;
      wn_x_d = newer_x_q;
      wn_y_d = newer_y_q;
      wp_x_d = in_i.point_x;
      wp_y_d = in_i.point_y;
      if (in_i.final_point) begin
        older_x_d = '0;
        older_y_d = '0;
        newer_x_d = '0;
        newer_y_d = '0;
        pts_d     = PTS_NONE;
      end else begin
        older_x_d = newer_x_q;
        older_y_d = newer_y_q;
        newer_x_d = in_i.point_x;
        newer_y_d = in_i.point_y;
        if (pts_q != PTS_TWO) begin
          pts_d = pts_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_x_q <= '0;
      older_y_q <= '0;
      newer_x_q <= '0;
      newer_y_q <= '0;
      pts_q     <= PTS_NONE;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      fin_q     <= 1'b0;
    end else begin
      older_x_q <= older_x_d;
      older_y_q <= older_y_d;
      newer_x_q <= newer_x_d;
      newer_y_q <= newer_y_d;
      pts_q     <= pts_d;
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      fin_q     <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wo_x_q <= wo_x_d;
    wo_y_q <= wo_y_d;
    wn_x_q <= wn_x_d;
    wn_y_q <= wn_y_d;
    wp_x_q <= wp_x_d;
    wp_y_q <= wp_y_d;
  end

  always_comb begin
    issue_o.valid     = busy_q;
    issue_o.x0        = wo_x_q;
    issue_o.y0        = wo_y_q;
    issue_o.x1        = wn_x_q;
    issue_o.y1        = wn_y_q;
    issue_o.x2        = wp_x_q;
    issue_o.y2        = wp_y_q;
    issue_o.idx       = cnt_q;
    issue_o.run_end   = last;
    issue_o.curve_end = (cnt_q == PASS_IDX) && fin_q;
  end

  `QBT_ASSERT_IMPL(a_pts_range, clk_i, rst_ni, 1'b1, pts_q != 2'd3)
  `QBT_ASSERT_NEXT(a_final_clears, clk_i, rst_ni, accept && in_i.final_point, pts_q == PTS_NONE)
  `QBT_ASSERT_NEXT(a_final_pass, clk_i, rst_ni, fire && (cnt_q == LAST_SAMPLE) && fin_q,
                   busy_q && (cnt_q == PASS_IDX))
  `QBT_ASSERT_IMPL(a_idx_range, clk_i, rst_ni, busy_q, cnt_q <= PASS_IDX)

endmodule

`default_nettype wire

FILE: rtl/qbt_blend.sv
// Weighted blend pipeline: weight lookup and products, then sum, rounding and result register.
`default_nettype none

module qbt_blend (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qbt_pkg::issue_t issue_i,
  output logic                 adv_o,
  qbt_curve_if.source          out_o
);
  import qbt_pkg::*;

  localparam int SW = AW - WFRAC;

  logic [WW-1:0]          w0, w1, w2;
  logic signed [PW-1:0]   px0_d, px1_d, px2_d, py0_d, py1_d, py2_d;
  logic signed [PW-1:0]   px0_q, px1_q, px2_q, py0_q, py1_q, py2_q;
  logic                   v1_q, run1_q, cend1_q;
  logic                   ov_q;
  logic signed [COORD_W-1:0] ox_q, oy_q, ox_d, oy_d;
  logic                   orun_q, ocend_q;

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PW-1:0] a,
    input logic signed [PW-1:0] b,
    input logic signed [PW-1:0] c
  );
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] sh;
    logic [SW-COORD_W:0]  hi;
    acc = AW'(a) + AW'(b) + AW'(c) + AW'(longint'(1) << (WFRAC - 1));
    sh  = SW'(acc >>> WFRAC);
    hi  = sh[SW-1:COORD_W-1];
    if ((hi == '0) || (hi == '1)) begin
      return sh[COORD_W-1:0];
    end else if (sh[SW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign adv_o = !ov_q || out_o.ready;

  always_comb begin
    w0    = W0_TAB[issue_i.idx];
    w1    = W1_TAB[issue_i.idx];
    w2    = W2_TAB[issue_i.idx];
    px0_d = PW'(issue_i.x0) * PW'($signed({1'b0, w0}));
    px1_d = PW'(issue_i.x1) * PW'($signed({1'b0, w1}));
    px2_d = PW'(issue_i.x2) * PW'($signed({1'b0, w2}));
    py0_d = PW'(issue_i.y0) * PW'($signed({1'b0, w0}));
    py1_d = PW'(issue_i.y1) * PW'($signed({1'b0, w1}));
    py2_d = PW'(issue_i.y2) * PW'($signed({1'b0, w2}));
    ox_d  = round_sat(px0_q, px1_q, px2_q);
    oy_d  = round_sat(py0_q, py1_q, py2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv_o) begin
      v1_q <= issue_i.valid;
      ov_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      px0_q   <= px0_d;
      px1_q   <= px1_d;
      px2_q   <= px2_d;
      py0_q   <= py0_d;
      py1_q   <= py1_d;
      py2_q   <= py2_d;
      run1_q  <= issue_i.run_end;
      cend1_q <= issue_i.curve_end;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      orun_q  <= run1_q;
      ocend_q <= cend1_q;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.curve_x   = ox_q;
  assign out_o.curve_y   = oy_q;
  assign out_o.run_end   = orun_q;
  assign out_o.curve_end = ocend_q;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the quadratic B-spline tessellator, with a directed table and random curves.
`timescale 1ns / 1ps

module tb;
  import qbt_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   run_end;
    logic   curve_end;
  } curve_pt_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_ECHO, ROW_SILENT} row_kind_e;

  typedef struct packed {
    coord_t    x;
    coord_t    y;
    logic      fin;
    row_kind_e kind;
  } point_row_t;

  localparam coord_t COORD_MAX    = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN    = 32'sh8000_0000;
  localparam int     DIR_N        = 19;
  localparam int     TOTAL_POINTS = 260;
  localparam int     HOLD_AT      = 70;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_AT     = 120;
  localparam int     STEADY_FROM  = 150;
  localparam int     STEADY_TO    = 200;
  localparam int     SETTLE       = 2 * SAMPLES + 10;
  localparam int     CYCLE_LIMIT  = 100000;

  logic clk_i;
  logic rst_ni;

  qbt_point_if point_ch ();
  qbt_curve_if curve_ch ();

  quadratic_bspline_tessellator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (point_ch),
    .out_o (curve_ch)
  );

  point_row_t dir_rows [DIR_N] = '{
    '{COORD_MAX, COORD_MIN, 1'b1, ROW_ECHO},
    '{COORD_MIN, COORD_MAX, 1'b1, ROW_ECHO},
    '{32'sd5, -32'sd7, 1'b0, ROW_ECHO},
    '{32'sd100, 32'sd200, 1'b1, ROW_ECHO},
    '{COORD_MAX, COORD_MIN, 1'b0, ROW_ECHO},
    '{COORD_MIN, COORD_MAX, 1'b0, ROW_SILENT},
    '{COORD_MAX, COORD_MIN, 1'b0, ROW_PREDICT},
    '{COORD_MIN, COORD_MIN, 1'b0, ROW_PREDICT},
    '{COORD_MAX, COORD_MAX, 1'b1, ROW_PREDICT},
    '{32'sd0, 32'sd0, 1'b0, ROW_ECHO},
    '{-32'sd1, -32'sd1, 1'b0, ROW_SILENT},
    '{32'sd1, 32'sd1, 1'b0, ROW_PREDICT},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, ROW_PREDICT},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, ROW_PREDICT},
    '{32'sh1234_5678, -32'sh1234_5678, 1'b1, ROW_PREDICT},
    '{-32'sd1, 32'sd0, 1'b0, ROW_ECHO},
    '{COORD_MAX, COORD_MAX, 1'b0, ROW_SILENT},
    '{COORD_MAX, COORD_MAX, 1'b0, ROW_PREDICT},
    '{-32'sd3, -32'sd5, 1'b1, ROW_PREDICT}
  };

  curve_pt_t  pending_pts[$];
  coord_t     older_x, older_y, newer_x, newer_y;
  logic [1:0] points_held;
  int         errors;
  int         points_sent;
  int         curves_sent;
  int         pts_checked;
  int         cycle_count;
  bit         steady;
  bit         hold_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic curve_pt_t point_at(input coord_t x, input coord_t y, input logic run,
                                         input logic fin);
    curve_pt_t pt;
    pt.x         = x;
    pt.y         = y;
    pt.run_end   = run;
    pt.curve_end = fin;
    return pt;
  endfunction

  function automatic void queue_expected(input curve_pt_t pt);
    pending_pts = {pending_pts, pt};
  endfunction

  function automatic longint span_weight(input longint sq);
    longint s2;
    s2 = longint'(SAMPLES) * longint'(SAMPLES);
    return (sq * (longint'(1) << WFRAC) + s2) / (2 * s2);
  endfunction

  function automatic coord_t mix_coord(input longint w0, input longint w1, input longint w2,
                                       input coord_t p0, input coord_t p1, input coord_t p2);
    longint acc;
    acc = w0 * longint'(p0) + w1 * longint'(p1) + w2 * longint'(p2);
    acc = (acc + (longint'(1) << (WFRAC - 1))) >>> WFRAC;
    if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
    if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
    return coord_t'(acc);
  endfunction

  // Computes the curve points caused by one control point and advances the window.
  task automatic tessellate_point(input coord_t px, input coord_t py, input logic fin,
                                  input bit keep);
    longint w0, w1, w2;
    int     j;
    if (points_held == 2'd0) begin
      if (keep) queue_expected(point_at(px, py, 1'b1, fin));
    end else if (points_held == 2'd1) begin
      if (keep && fin) queue_expected(point_at(px, py, 1'b1, 1'b1));
    end else begin
      for (j = 0; j < SAMPLES; j++) begin
        w0 = span_weight(longint'(SAMPLES - j) * longint'(SAMPLES - j));
        w2 = span_weight(longint'(j) * longint'(j));
        w1 = (longint'(1) << WFRAC) - w0 - w2;
        if (keep) begin
          queue_expected(point_at(mix_coord(w0, w1, w2, older_x, newer_x, px),
                                  mix_coord(w0, w1, w2, older_y, newer_y, py),
                                  !fin && (j == SAMPLES - 1), 1'b0));
        end
      end
      if (keep && fin) queue_expected(point_at(px, py, 1'b1, 1'b1));
    end
    if (fin) begin
      older_x     = '0;
      older_y     = '0;
      newer_x     = '0;
      newer_y     = '0;
      points_held = 2'd0;
    end else begin
      older_x = newer_x;
      older_y = newer_y;
      newer_x = px;
      newer_y = py;
      if (points_held != 2'd2) points_held = points_held + 2'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 40) begin
      $display("[%0t] curve point %0d: %s is %0d, expected %0d", $time, pts_checked, what,
               got, want);
    end
    errors++;
  endtask

  task automatic check_curve_point();
    curve_pt_t want;
    if (pending_pts.size() == 0) begin
      report_mismatch("unrequested point x", longint'(curve_ch.curve_x), 0);
    end else begin
      want = pending_pts.pop_front();
      if (curve_ch.curve_x !== want.x)
        report_mismatch("curve_x", longint'(curve_ch.curve_x), longint'(want.x));
      if (curve_ch.curve_y !== want.y)
        report_mismatch("curve_y", longint'(curve_ch.curve_y), longint'(want.y));
      if (curve_ch.run_end !== want.run_end)
        report_mismatch("run_end", longint'(curve_ch.run_end), longint'(want.run_end));
      if (curve_ch.curve_end !== want.curve_end)
        report_mismatch("curve_end", longint'(curve_ch.curve_end), longint'(want.curve_end));
    end
    pts_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && curve_ch.valid && curve_ch.ready) check_curve_point();
  end

  task automatic send_point(input coord_t x, input coord_t y, input logic fin);
    while (!steady && $urandom_range(99) < 12) begin
      point_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_ch.valid       <= 1'b1;
    point_ch.point_x     <= x;
    point_ch.point_y     <= y;
    point_ch.final_point <= fin;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    points_sent++;
    if (fin) curves_sent++;
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return coord_t'($urandom_range(400)) - coord_t'(200);
      default: return coord_t'($urandom);
    endcase
  endfunction

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    curve_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        curve_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        curve_ch.ready <= 1'b0;
      end else begin
        curve_ch.ready <= steady || ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int     i, k, len;
    coord_t x, y;
    logic   fin;
    errors       = 0;
    points_sent  = 0;
    curves_sent  = 0;
    pts_checked  = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    older_x      = '0;
    older_y      = '0;
    newer_x      = '0;
    newer_y      = '0;
    points_held  = 2'd0;
    rst_ni               <= 1'b0;
    point_ch.valid       <= 1'b0;
    point_ch.point_x     <= '0;
    point_ch.point_y     <= '0;
    point_ch.final_point <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin);
      tessellate_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin,
                       dir_rows[i].kind == ROW_PREDICT);
      if (dir_rows[i].kind == ROW_ECHO)
        queue_expected(point_at(dir_rows[i].x, dir_rows[i].y, 1'b1, dir_rows[i].fin));
    end

    while (points_sent < TOTAL_POINTS) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = 2;
        default: len = $urandom_range(3, 12);
      endcase
      for (k = 0; k < len; k++) begin
        if (points_sent == HOLD_AT) hold_request = 1'b1;
        if (points_sent == DRAIN_AT) begin
          point_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_pts.size() != 0) @(posedge clk_i);
        end
        steady = (points_sent >= STEADY_FROM) && (points_sent < STEADY_TO);
        x   = pick_coord();
        y   = pick_coord();
        fin = (k == len - 1);
        send_point(x, y, fin);
        tessellate_point(x, y, fin, 1'b1);
      end
    end
    point_ch.valid <= 1'b0;
    steady = 1'b0;

    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Fed %0d control points in %0d closed curves, directed extremes first.",
             points_sent, curves_sent);
    $display("Checked %0d curve points across output hold-off, drain and stall phases.",
             pts_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
